@@ rtl/core/tsc_pkg.sv @@
// Shared types, constants and term tables for the Taylor sine/cosine block.
// No dependencies; used by tsc_front, tsc_queue, tsc_back and taylor_sine_cosine.
package tsc_pkg;

  localparam int PHASE_W = 32;
  localparam int OUT_W   = 32;
  localparam int MAG_W   = 32;
  localparam int QDEPTH  = 2;

  localparam logic signed [32:0] PI_Q24     = 33'sd52707179;
  localparam logic signed [32:0] TWO_PI_Q24 = 33'sd105414358;
  localparam logic [32:0]        ONE_Q30    = 33'h040000000;

  localparam logic [2:0] SIN_LAST = 3'd4;  // five terms after t1
  localparam logic [2:0] COS_LAST = 3'd5;  // six terms after t0

  typedef struct packed {
    logic              neg;
    logic [MAG_W-1:0]  mag;
  } tsc_item_t;

  // n*(n-1) for each later term
  function automatic logic [7:0] term_div(input logic cos_sel, input logic [2:0] k);
    logic [7:0] d;
    d = 8'd2;
    if (cos_sel) begin
      unique case (k)
        3'd0: d = 8'd2;
        3'd1: d = 8'd12;
        3'd2: d = 8'd30;
        3'd3: d = 8'd56;
        3'd4: d = 8'd90;
        3'd5: d = 8'd132;
        default: d = 8'd2;
      endcase
    end else begin
      unique case (k)
        3'd0: d = 8'd6;
        3'd1: d = 8'd20;
        3'd2: d = 8'd42;
        3'd3: d = 8'd72;
        3'd4: d = 8'd110;
        default: d = 8'd6;
      endcase
    end
    return d;
  endfunction

  // floor(2^32 / d), coarse reciprocal
  function automatic logic [31:0] term_recip(input logic cos_sel, input logic [2:0] k);
    logic [31:0] r;
    r = 32'd2147483648;
    if (cos_sel) begin
      unique case (k)
        3'd0: r = 32'd2147483648;
        3'd1: r = 32'd357913941;
        3'd2: r = 32'd143165576;
        3'd3: r = 32'd76695844;
        3'd4: r = 32'd47721858;
        3'd5: r = 32'd32537631;
        default: r = 32'd2147483648;
      endcase
    end else begin
      unique case (k)
        3'd0: r = 32'd715827882;
        3'd1: r = 32'd214748364;
        3'd2: r = 32'd102261126;
        3'd3: r = 32'd59652323;
        3'd4: r = 32'd39045157;
        default: r = 32'd715827882;
      endcase
    end
    return r;
  endfunction

  // ceil(2^20 / d), exact quotient for a 12-bit remainder
  function automatic logic [19:0] term_fine(input logic cos_sel, input logic [2:0] k);
    logic [19:0] f;
    f = 20'd524288;
    if (cos_sel) begin
      unique case (k)
        3'd0: f = 20'd524288;
        3'd1: f = 20'd87382;
        3'd2: f = 20'd34953;
        3'd3: f = 20'd18725;
        3'd4: f = 20'd11651;
        3'd5: f = 20'd7944;
        default: f = 20'd524288;
      endcase
    end else begin
      unique case (k)
        3'd0: f = 20'd174763;
        3'd1: f = 20'd52429;
        3'd2: f = 20'd24967;
        3'd3: f = 20'd14564;
        3'd4: f = 20'd9533;
        default: f = 20'd174763;
      endcase
    end
    return f;
  endfunction

  function automatic logic [OUT_W-1:0] sat32(input logic signed [36:0] v);
    logic [OUT_W-1:0] s;
    if (v > 37'sd2147483647)
      s = 32'h7fffffff;
    else if (v < -37'sd2147483648)
      s = 32'h80000000;
    else
      s = v[31:0];
    return s;
  endfunction

endpackage

@@ rtl/core/tsc_front.sv @@
// Front end: accepts a phase, wraps it into [-pi, pi] in five greedy steps of 2^j * 2pi.
// Depends on tsc_pkg; feeds tsc_queue with sign and Q.30 magnitude.
module tsc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tsc_pkg::PHASE_W-1:0]       in_phase,
  output logic                              push,
  input  logic                              full,
  output tsc_pkg::tsc_item_t                item
);

  logic              busy;
  logic [2:0]        steps;
  logic              pos;
  logic              neg;
  logic signed [32:0] ph;
  logic signed [32:0] in_ext;
  logic signed [32:0] stride;
  logic signed [32:0] cand_sub;
  logic signed [32:0] cand_add;
  logic [2:0]        j;
  logic signed [32:0] ph_abs;

  assign in_ready = !busy;
  assign in_ext   = {in_phase[tsc_pkg::PHASE_W-1], in_phase};
  assign j        = steps - 3'd1;
  assign stride   = tsc_pkg::TWO_PI_Q24 <<< j;
  assign cand_sub = ph - stride;
  assign cand_add = ph + stride;
  assign ph_abs   = ph[32] ? -ph : ph;

  assign push     = busy && (steps == 3'd0) && !full;
  assign item.neg = ph[32];
  assign item.mag = {ph_abs[25:0], 6'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= 3'd0;
    end else if (in_valid && in_ready) begin
      busy  <= 1'b1;
      steps <= 3'd5;
      ph    <= in_ext;
      pos   <= in_ext > tsc_pkg::PI_Q24;
      neg   <= in_ext < -tsc_pkg::PI_Q24;
    end else if (busy) begin
      if (steps != 3'd0) begin
        steps <= steps - 3'd1;
        // take the largest multiple that keeps the phase inside the window
        if (pos && (cand_sub > -tsc_pkg::PI_Q24))
          ph <= cand_sub;
        else if (neg && (cand_add < tsc_pkg::PI_Q24))
          ph <= cand_add;
      end else if (!full) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/tsc_queue.sv @@
// Two-entry request queue between the reduction front end and the series back end.
// Depends on tsc_pkg for the entry type.
module tsc_queue #(
  parameter int DEPTH = tsc_pkg::QDEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  tsc_pkg::tsc_item_t wr_item,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output tsc_pkg::tsc_item_t rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tsc_pkg::tsc_item_t mem [DEPTH];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [AW:0]        count;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)
        count <= count + 1'b1;
      else if (pop && !push)
        count <= count - 1'b1;
    end
  end

endmodule

@@ rtl/core/tsc_back.sv @@
// Back end: evaluates both Taylor series on one shared multiplier, term by term.
// Depends on tsc_pkg for term tables and saturation; drives the output register.
module tsc_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       empty,
  output logic                       pop,
  input  tsc_pkg::tsc_item_t         item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tsc_pkg::OUT_W-1:0]  out_sine,
  output logic [tsc_pkg::OUT_W-1:0]  out_cosine
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_X2   = 3'd1;
  localparam logic [2:0] B_P    = 3'd2;
  localparam logic [2:0] B_Q0   = 3'd3;
  localparam logic [2:0] B_R    = 3'd4;
  localparam logic [2:0] B_Q1   = 3'd5;

  logic [2:0]          state;
  logic                neg;
  logic [31:0]         mag;
  logic [33:0]         x2;
  logic [32:0]         t;
  logic [35:0]         p;
  logic [35:0]         q0;
  logic [11:0]         rem;
  logic                cos_sel;
  logic [2:0]          k;
  logic signed [36:0]  acc;
  logic signed [36:0]  sacc;

  logic [33:0]         mul_a;
  logic [33:0]         mul_b;
  logic [67:0]         prod;
  logic [7:0]          dv;
  logic [43:0]         qd;
  logic [31:0]         fine_prod;
  logic [35:0]         q_new;
  logic signed [36:0]  q_s;
  logic signed [36:0]  acc_next;
  logic                last;
  logic                finish;
  logic                load_out;
  logic signed [36:0]  sine_val;

  always_comb begin
    unique case (state)
      B_X2:    begin mul_a = {2'b0, mag};      mul_b = {2'b0, mag}; end
      B_P:     begin mul_a = {1'b0, t};        mul_b = x2; end
      B_Q0:    begin mul_a = {2'b0, p[35:4]};
                     mul_b = {2'b0, tsc_pkg::term_recip(cos_sel, k)}; end
      default: begin mul_a = '0;               mul_b = '0; end
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign dv        = tsc_pkg::term_div(cos_sel, k);
  assign qd        = q0 * dv;
  assign fine_prod = rem * tsc_pkg::term_fine(cos_sel, k);
  assign q_new     = q0 + 36'(fine_prod[31:20]);
  assign q_s       = 37'($signed({1'b0, q_new}));
  // odd-numbered terms after the first one are subtracted
  assign acc_next  = k[0] ? acc + q_s : acc - q_s;
  assign last      = cos_sel ? (k == tsc_pkg::COS_LAST) : (k == tsc_pkg::SIN_LAST);
  assign finish    = (state == B_Q1) && cos_sel && last;
  assign load_out  = finish && (!out_valid || out_ready);
  assign sine_val  = neg ? -sacc : sacc;
  assign pop       = (state == B_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out)
        out_valid <= 1'b1;
      else if (out_valid && out_ready)
        out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            neg   <= item.neg;
            mag   <= item.mag;
            state <= B_X2;
          end
        end
        B_X2: begin
          x2      <= prod[63:30];
          t       <= {1'b0, mag};
          acc     <= 37'($signed({1'b0, mag}));
          cos_sel <= 1'b0;
          k       <= 3'd0;
          state   <= B_P;
        end
        B_P: begin
          p     <= prod[65:30];
          state <= B_Q0;
        end
        B_Q0: begin
          q0    <= prod[63:28];
          state <= B_R;
        end
        B_R: begin
          rem   <= p[11:0] - qd[11:0];
          state <= B_Q1;
        end
        B_Q1: begin
          if (finish) begin
            // hold the final term until the output register frees up
            if (load_out) begin
              out_sine   <= tsc_pkg::sat32(sine_val);
              out_cosine <= tsc_pkg::sat32(acc_next);
              state      <= B_IDLE;
            end
          end else if (last) begin
            sacc    <= acc_next;
            cos_sel <= 1'b1;
            k       <= 3'd0;
            t       <= tsc_pkg::ONE_Q30;
            acc     <= 37'($signed({4'b0, tsc_pkg::ONE_Q30}));
            state   <= B_P;
          end else begin
            t     <= q_new[32:0];
            acc   <= acc_next;
            k     <= k + 3'd1;
            state <= B_P;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/taylor_sine_cosine.sv @@
// Channel   Dir  Width  Contents
// s_axis    in   32     tdata: phase (Q8.24)
// m_axis    out  64     tdata: sine [31:0], cosine [63:32] (Q2.30)
//
// An item passes through the front end (five wrap steps and a push), then the back
// end: a pop, squaring, then the states B_P, B_Q0, B_R and B_Q1 for each series term
// on the one shared multiplier, eleven terms. The back end sets throughput: it pops
// an item only when idle. Reset is synchronous and empties the queue and output register.
// A stalled output holds the back end on its last term; the front keeps filling the queue.
// Depends on tsc_pkg, tsc_front, tsc_queue, tsc_back.
module taylor_sine_cosine #(
  parameter int QDEPTH = tsc_pkg::QDEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] phase
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [31:0] sine, [63:32] cosine
);

  tsc_pkg::tsc_item_t f_item;
  tsc_pkg::tsc_item_t b_item;
  logic               push;
  logic               full;
  logic               pop;
  logic               empty;
  logic [31:0]        sine;
  logic [31:0]        cosine;

  tsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_phase (s_tdata),
    .push     (push),
    .full     (full),
    .item     (f_item)
  );

  tsc_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (f_item),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .rd_item (b_item)
  );

  tsc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .pop        (pop),
    .item       (b_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sine   (sine),
    .out_cosine (cosine)
  );

  assign m_tdata = {cosine, sine};

endmodule

@@ tb/sv/tb.sv @@
// Testbench for taylor_sine_cosine: phase requests in, sine/cosine results out.
// Checks every result against a fixed-point Taylor predictor; needs tsc_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

  localparam longint PI_FIX   = 64'sd52707179;
  localparam int     WDOG_MAX = 5000;

  typedef struct {
    logic [31:0] sine;
    logic [31:0] cosine;
  } trig_t;

  typedef struct {
    logic [31:0] phase;
    bit          typed;
    logic [31:0] sine;
    logic [31:0] cosine;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  trig_t       pending_trig[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          rx_enable = 1'b0;

  taylor_sine_cosine dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // floor(a*b / 2^30) with full-width product
  function automatic longint unsigned mul_q30(input longint unsigned a,
                                              input longint unsigned b);
    logic [127:0] p;
    p = a * b;
    return p[93:30];
  endfunction

  function automatic longint taylor_sum(input longint unsigned t0, input int n0,
                                        input longint unsigned x2, input int count);
    longint unsigned t;
    int n;
    longint acc;
    t = t0;
    n = n0;
    acc = longint'(t);
    for (int k = 1; k < count; k++) begin
      n += 2;
      t = mul_q30(t, x2) / longint'(n * (n - 1));
      if (k & 1) acc -= longint'(t);
      else acc += longint'(t);
    end
    return acc;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic trig_t predict_trig(input logic [31:0] phase);
    longint ph, x30, s;
    longint unsigned mag, x2;
    trig_t r;
    ph = longint'(signed'(phase));
    // exactly +/-pi is left unwrapped
    while (ph < -PI_FIX) ph += 2 * PI_FIX;
    while (ph > PI_FIX) ph -= 2 * PI_FIX;
    x30 = ph * 64;
    mag = (x30 < 0) ? -x30 : x30;
    x2 = (mag * mag) >> 30;
    s = taylor_sum(mag, 1, x2, 6);
    if (x30 < 0) s = -s;
    r.sine = clamp32(s);
    r.cosine = clamp32(taylor_sum(64'd1073741824, 0, x2, 7));
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // check results, then record new requests
  always @(posedge clk) begin
    trig_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_trig.size() == 0) begin
          report("unexpected result", m_tdata[31:0], 32'h0);
        end else begin
          e = pending_trig.pop_front();
          if (m_tdata[31:0] !== e.sine) report("sine", m_tdata[31:0], e.sine);
          if (m_tdata[63:32] !== e.cosine) report("cosine", m_tdata[63:32], e.cosine);
        end
      end
      if (s_tvalid && s_tready) pending_trig.push_back(predict_trig(s_tdata));
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_MAX) begin
        $display("** taylor_sine_cosine: FAILED **");
        $finish;
      end
    end
  end

  // receiver: stall pattern with long open stretches
  always @(negedge clk) begin
    int slot;
    slot = $urandom_range(0, 99);
    if (!rx_enable) m_tready = 1'b0;
    else if (($time / 10) % 2000 < 400) m_tready = 1'b1;
    else m_tready = (slot < 65);
  end

  task automatic send_phase(input logic [31:0] p);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = p;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    s_tvalid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [31:0] random_phase();
    int sel;
    longint base;
    sel = $urandom_range(0, 9);
    base = PI_FIX * $urandom_range(0, 80) - PI_FIX * 40;
    case (sel)
      0, 1, 2: return $urandom();
      3, 4:    return 32'(base + $urandom_range(0, 8) - 4);   // near multiples of pi
      default: return $urandom_range(0, 2 * 52707179) - 52707179; // principal range
    endcase
  endfunction

  vec_t directed[] = '{
    '{32'h00000000, 1'b1, 32'h00000000, 32'h40000000},
    '{32'd52707179, 1'b0, 0, 0},
    '{-32'sd52707179, 1'b0, 0, 0},
    '{32'd52707180, 1'b0, 0, 0},
    '{-32'sd52707180, 1'b0, 0, 0},
    '{32'd105414358, 1'b0, 0, 0},
    '{-32'sd105414358, 1'b0, 0, 0},
    '{32'd26353589, 1'b0, 0, 0},
    '{-32'sd26353589, 1'b0, 0, 0},
    '{32'h00000001, 1'b0, 0, 0},
    '{32'hffffffff, 1'b0, 0, 0},
    '{32'h01000000, 1'b0, 0, 0},
    '{32'h7fffffff, 1'b0, 0, 0},
    '{32'h80000000, 1'b0, 0, 0},
    '{32'h55555555, 1'b0, 0, 0},
    '{32'haaaaaaaa, 1'b0, 0, 0},
    '{32'd158121537, 1'b0, 0, 0},
    '{-32'sd158121537, 1'b0, 0, 0}
  };

  initial begin
    int burst;
    trig_t chk;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    rx_enable = 1'b1;

    foreach (directed[i]) begin
      if (directed[i].typed) begin
        chk = predict_trig(directed[i].phase);
        if (chk.sine !== directed[i].sine) report("table sine", chk.sine, directed[i].sine);
        if (chk.cosine !== directed[i].cosine)
          report("table cosine", chk.cosine, directed[i].cosine);
      end
      send_phase(directed[i].phase);
    end
    idle_gap(3);

    for (int n = 0; n < 1900; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) send_phase(random_phase());
      n += burst;
      if (n >= 950 && n < 950 + burst) begin
        // hold off until the pipeline drains
        idle_gap(0);
        while (pending_trig.size() != 0) @(negedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        idle_gap($urandom_range(0, 60));
      end
    end
    idle_gap(0);

    while (pending_trig.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) $display("** taylor_sine_cosine: PASSED **");
    else $display("** taylor_sine_cosine: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tsc_pkg.sv
rtl/core/tsc_front.sv
rtl/core/tsc_queue.sv
rtl/core/tsc_back.sv
rtl/core/taylor_sine_cosine.sv
tb/sv/tb.sv
